/* hdl/mns_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mns_pkg;

    // Note memory
    localparam int NOTE_DEPTH = 256;
    localparam int NOTE_AW    = $clog2(NOTE_DEPTH);
    localparam int SUM_W      = 10;

    // Field widths
    localparam int ADDR_W  = 8;
    localparam int PITCH_W = 16;
    localparam int LEN_W   = 8;
    localparam int COUNT_W = 9;
    localparam int BPM_W   = 16;
    localparam int MS_W    = 22;
    localparam int SIXT_W  = 14;
    localparam int WORD_W  = LEN_W + PITCH_W;

    // Timing constants
    localparam logic [MS_W-1:0]   GAP_MS               = MS_W'(30);
    localparam logic [SIXT_W-1:0] TEMPO_DIVIDEND       = SIXT_W'(15000);
    localparam logic [SIXT_W-1:0] DEFAULT_SIXTEENTH_MS = SIXT_W'(100);
    localparam logic [MS_W-1:0]   ELAPSED_MAX          = {MS_W{1'b1}};

    // Tempo divider: one quotient bit per step
    localparam int DIV_STEPS = SIXT_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // Command queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Opcodes on the input channel
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    typedef enum logic [2:0] {
        K_TICK,
        K_WRITE,
        K_START,
        K_NOP,
        K_STOP
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   address;
        logic [PITCH_W-1:0]  pitch;
        logic [LEN_W-1:0]    length;
        logic [COUNT_W-1:0]  count;
        logic [BPM_W-1:0]    bpm;
    } t_cmd;

    typedef struct packed {
        logic               tone_start;
        logic [PITCH_W-1:0] freq;
        logic [MS_W-1:0]    ms;
        logic               silence;
        logic               done;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_SLOT,
        S_EVAL,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

/* hdl/mns_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module mns_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [mns_pkg::ADDR_W-1:0]   i_address,
    input  wire logic [mns_pkg::PITCH_W-1:0]  i_pitch_hz,
    input  wire logic [mns_pkg::LEN_W-1:0]    i_note_length,
    input  wire logic [mns_pkg::COUNT_W-1:0]  i_note_count,
    input  wire logic [mns_pkg::BPM_W-1:0]    i_tempo_bpm,
    output logic                              o_push,
    output mns_pkg::t_cmd                     o_cmd,
    input  wire logic                         i_push_ready
);

    logic          r_stage_valid;
    mns_pkg::t_cmd r_stage;
    mns_pkg::t_kind c_kind;
    logic          c_accept;

    // Classify: a start with zero count does nothing
    always_comb begin
        unique case (i_opcode)
            mns_pkg::OP_TICK:  c_kind = mns_pkg::K_TICK;
            mns_pkg::OP_WRITE: c_kind = mns_pkg::K_WRITE;
            mns_pkg::OP_START: c_kind = (i_note_count == '0) ? mns_pkg::K_NOP
                                                             : mns_pkg::K_START;
            default:           c_kind = mns_pkg::K_STOP;
        endcase
    end

    assign o_in_ready = !r_stage_valid || i_push_ready;
    assign c_accept   = i_in_valid && o_in_ready;
    assign o_push     = r_stage_valid;
    assign o_cmd      = r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (c_accept) begin
            r_stage_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_stage_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_stage.kind    <= c_kind;
            r_stage.address <= i_address;
            r_stage.pitch   <= i_pitch_hz;
            r_stage.length  <= i_note_length;
            r_stage.count   <= i_note_count;
            r_stage.bpm     <= i_tempo_bpm;
        end
    end

endmodule

`default_nettype wire

/* hdl/mns_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module mns_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mns_pkg::t_cmd i_cmd,
    output logic               o_push_ready,
    output logic               o_head_valid,
    output mns_pkg::t_cmd      o_head,
    input  wire logic          i_pop
);

    mns_pkg::t_cmd             r_entry [mns_pkg::QDEPTH];
    logic [mns_pkg::QAW-1:0]   r_wr_ptr;
    logic [mns_pkg::QAW-1:0]   r_rd_ptr;
    logic [mns_pkg::QAW:0]     r_fill;
    logic                      c_do_push;
    logic                      c_do_pop;

    assign o_push_ready = (r_fill != (mns_pkg::QAW+1)'(mns_pkg::QDEPTH));
    assign o_head_valid = (r_fill != '0);
    assign o_head       = r_entry[r_rd_ptr];
    assign c_do_push    = i_push && o_push_ready;
    assign c_do_pop     = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (c_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (c_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({c_do_push, c_do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* hdl/mns_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module mns_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_head_valid,
    input  wire mns_pkg::t_cmd                 i_head,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_tone_start,
    output logic [mns_pkg::PITCH_W-1:0]        o_tone_freq,
    output logic [mns_pkg::MS_W-1:0]           o_tone_ms,
    output logic                               o_silence,
    output logic                               o_playing,
    output logic                               o_song_done
);

    mns_pkg::t_state r_state;
    mns_pkg::t_state n_state;

    // Note memory, read data registered
    logic [mns_pkg::WORD_W-1:0]  r_note_mem [mns_pkg::NOTE_DEPTH];
    logic [mns_pkg::WORD_W-1:0]  r_rd_data;

    // Song state
    logic [mns_pkg::ADDR_W-1:0]  r_first;
    logic [mns_pkg::COUNT_W-1:0] r_count;
    logic [mns_pkg::COUNT_W-1:0] r_index;
    logic [mns_pkg::SIXT_W-1:0]  r_sixteenth;
    logic [mns_pkg::MS_W-1:0]    r_elapsed;
    logic                        r_active;
    logic                        r_issue;

    // Current note
    logic [mns_pkg::MS_W-1:0]    r_slot;
    logic [mns_pkg::PITCH_W-1:0] r_freq;

    // Tempo divider
    logic [mns_pkg::BPM_W-1:0]   r_bpm;
    logic [mns_pkg::BPM_W-1:0]   r_rem;
    logic [mns_pkg::SIXT_W-1:0]  r_quo;
    logic [mns_pkg::DIV_CW-1:0]  r_div_cnt;

    mns_pkg::t_result            r_res;

    // Decode
    logic [mns_pkg::BPM_W:0]     c_trial;
    logic                        c_ge;
    logic [mns_pkg::BPM_W-1:0]   c_rem_next;
    logic [mns_pkg::SIXT_W-1:0]  c_quo_next;
    logic                        c_div_last;
    logic [mns_pkg::SUM_W-1:0]   c_addr_sum;
    logic [mns_pkg::NOTE_AW-1:0] c_rd_addr;
    logic [mns_pkg::COUNT_W-1:0] c_idx_next;
    logic                        c_slot_over;
    logic                        c_song_end;
    logic                        c_out_free;
    logic [mns_pkg::MS_W-1:0]    c_tone_ms;

    assign c_trial    = {r_rem, r_quo[mns_pkg::SIXT_W-1]};
    assign c_ge       = (c_trial >= {1'b0, r_bpm});
    assign c_rem_next = c_ge ? mns_pkg::BPM_W'(c_trial - {1'b0, r_bpm})
                             : mns_pkg::BPM_W'(c_trial);
    assign c_quo_next = {r_quo[mns_pkg::SIXT_W-2:0], c_ge};
    assign c_div_last = (r_div_cnt == mns_pkg::DIV_CW'(mns_pkg::DIV_STEPS - 1));

    assign c_addr_sum  = mns_pkg::SUM_W'(r_first) + mns_pkg::SUM_W'(r_index);
    assign c_rd_addr   = mns_pkg::NOTE_AW'(c_addr_sum);
    assign c_idx_next  = r_index + 1'b1;
    assign c_slot_over = (r_elapsed >= r_slot);
    assign c_song_end  = (c_idx_next >= r_count);
    assign c_out_free  = !o_out_valid || i_out_ready;
    assign c_tone_ms   = (r_slot > mns_pkg::GAP_MS) ? (r_slot - mns_pkg::GAP_MS) : r_slot;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mns_pkg::S_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head.kind)
                        mns_pkg::K_TICK:
                            n_state = r_active ? mns_pkg::S_READ : mns_pkg::S_RESP;
                        mns_pkg::K_START:
                            n_state = (i_head.bpm == '0) ? mns_pkg::S_READ
                                                         : mns_pkg::S_DIV;
                        default:
                            n_state = mns_pkg::S_RESP;
                    endcase
                end
            end
            mns_pkg::S_DIV: begin
                if (c_div_last) begin
                    n_state = mns_pkg::S_READ;
                end
            end
            mns_pkg::S_READ: n_state = mns_pkg::S_SLOT;
            mns_pkg::S_SLOT: n_state = mns_pkg::S_EVAL;
            mns_pkg::S_EVAL: begin
                if (!r_issue && c_slot_over && !c_song_end) begin
                    n_state = mns_pkg::S_READ;
                end else begin
                    n_state = mns_pkg::S_RESP;
                end
            end
            mns_pkg::S_RESP: begin
                if (c_out_free) begin
                    n_state = mns_pkg::S_IDLE;
                end
            end
            default: n_state = mns_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop = (r_state == mns_pkg::S_IDLE) && i_head_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mns_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Song control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= '0;
            r_count     <= '0;
            r_index     <= '0;
            r_sixteenth <= '0;
            r_elapsed   <= '0;
            r_active    <= 1'b0;
            r_issue     <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            unique case (r_state)
                mns_pkg::S_IDLE: begin
                    if (i_head_valid) begin
                        unique case (i_head.kind)
                            mns_pkg::K_TICK: begin
                                if (r_active) begin
                                    if (r_elapsed != mns_pkg::ELAPSED_MAX) begin
                                        r_elapsed <= r_elapsed + 1'b1;
                                    end
                                    r_issue <= 1'b0;
                                end
                            end
                            mns_pkg::K_START: begin
                                r_first   <= i_head.address;
                                r_count   <= i_head.count;
                                r_index   <= '0;
                                r_active  <= 1'b1;
                                r_issue   <= 1'b1;
                                r_div_cnt <= '0;
                                if (i_head.bpm == '0) begin
                                    r_sixteenth <= mns_pkg::DEFAULT_SIXTEENTH_MS;
                                end
                            end
                            mns_pkg::K_STOP: r_active <= 1'b0;
                            default: ;
                        endcase
                    end
                end
                mns_pkg::S_DIV: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (c_div_last) begin
                        r_sixteenth <= c_quo_next;
                    end
                end
                mns_pkg::S_EVAL: begin
                    if (r_issue) begin
                        r_elapsed <= '0;
                    end else if (c_slot_over) begin
                        // Advance to the next note, or end the song
                        r_index <= c_idx_next;
                        if (c_song_end) begin
                            r_active <= 1'b0;
                        end else begin
                            r_issue <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Divider, note fetch and pending result
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mns_pkg::S_IDLE: begin
                r_res <= '0;
                if (i_head_valid) begin
                    r_bpm <= i_head.bpm;
                    r_rem <= '0;
                    r_quo <= mns_pkg::TEMPO_DIVIDEND;
                    if (i_head.kind == mns_pkg::K_STOP) begin
                        r_res.silence <= 1'b1;
                    end
                end
            end
            mns_pkg::S_DIV: begin
                r_rem <= c_rem_next;
                r_quo <= c_quo_next;
            end
            mns_pkg::S_SLOT: begin
                r_slot <= mns_pkg::MS_W'(
                    {{(mns_pkg::MS_W-mns_pkg::LEN_W){1'b0}},
                     r_rd_data[mns_pkg::WORD_W-1:mns_pkg::PITCH_W]} *
                    {{(mns_pkg::MS_W-mns_pkg::SIXT_W){1'b0}}, r_sixteenth});
                r_freq <= r_rd_data[mns_pkg::PITCH_W-1:0];
            end
            mns_pkg::S_EVAL: begin
                r_res <= '0;
                if (r_issue) begin
                    if (r_freq == '0) begin
                        r_res.silence <= 1'b1;
                    end else begin
                        r_res.tone_start <= 1'b1;
                        r_res.freq       <= r_freq;
                        r_res.ms         <= c_tone_ms;
                    end
                end else if (c_slot_over && c_song_end) begin
                    r_res.silence <= 1'b1;
                    r_res.done    <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == mns_pkg::K_WRITE)) begin
            r_note_mem[mns_pkg::NOTE_AW'(i_head.address)] <= {i_head.length, i_head.pitch};
        end
        if (r_state == mns_pkg::S_READ) begin
            r_rd_data <= r_note_mem[c_rd_addr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if ((r_state == mns_pkg::S_RESP) && c_out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == mns_pkg::S_RESP) && c_out_free) begin
            o_tone_start <= r_res.tone_start;
            o_tone_freq  <= r_res.freq;
            o_tone_ms    <= r_res.ms;
            o_silence    <= r_res.silence;
            o_song_done  <= r_res.done;
            o_playing    <= r_active;
        end
    end

`ifndef SYNTHESIS
    a_done_not_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_song_done) |-> !o_playing)
        else $error("song end reported while still playing");

    a_tone_not_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_tone_start && o_silence))
        else $error("tone and silence in one word");

    a_index_in_song: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_index < r_count))
        else $error("note index past song end while active");

    a_div_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mns_pkg::S_DIV) |->
            (r_div_cnt < mns_pkg::DIV_CW'(mns_pkg::DIV_STEPS)))
        else $error("divider ran past its last step");
`endif

endmodule

`default_nettype wire

/* hdl/melody_note_sequencer_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Fields
// input     in         i_in_valid / o_in_ready   opcode address pitch_hz note_length
//                                                note_count tempo_bpm
// result    out        o_out_valid / i_out_ready tone_start tone_freq tone_ms silence
//                                                playing song_done
//
// One result word per input word. In the sequencer, write, stop and an idle tick
// go straight to the result state; a tick while playing reads, times and checks the
// current note, and the next one too when it moves on; a start does the same, after
// a tempo divide unless tempo is 0; the divider retires one quotient bit per cycle.
// Reset is synchronous, active low; the note memory is not cleared. A short
// command queue keeps input accepted while the sequencer works or waits.

module melody_note_sequencer_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [mns_pkg::ADDR_W-1:0]   i_address,
    input  wire logic [mns_pkg::PITCH_W-1:0]  i_pitch_hz,
    input  wire logic [mns_pkg::LEN_W-1:0]    i_note_length,
    input  wire logic [mns_pkg::COUNT_W-1:0]  i_note_count,
    input  wire logic [mns_pkg::BPM_W-1:0]    i_tempo_bpm,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_tone_start,
    output logic [mns_pkg::PITCH_W-1:0]       o_tone_freq,
    output logic [mns_pkg::MS_W-1:0]          o_tone_ms,
    output logic                              o_silence,
    output logic                              o_playing,
    output logic                              o_song_done
);

    // Intake to queue
    logic          w_push;
    logic          w_push_ready;
    mns_pkg::t_cmd w_push_cmd;

    // Queue to sequencer
    logic          w_head_valid;
    logic          w_pop;
    mns_pkg::t_cmd w_head;

    // Accept and classify each input word
    mns_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_address     (i_address),
        .i_pitch_hz    (i_pitch_hz),
        .i_note_length (i_note_length),
        .i_note_count  (i_note_count),
        .i_tempo_bpm   (i_tempo_bpm),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd),
        .i_push_ready  (w_push_ready)
    );

    // Hold classified commands until the sequencer is free
    mns_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_push_cmd),
        .o_push_ready (w_push_ready),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // Run the song: note memory, tempo divider, slot timing, result register
    mns_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_tone_start (o_tone_start),
        .o_tone_freq  (o_tone_freq),
        .o_tone_ms    (o_tone_ms),
        .o_silence    (o_silence),
        .o_playing    (o_playing),
        .o_song_done  (o_song_done)
    );

endmodule

`default_nettype wire

/* tb/melody_checker.sv */
`timescale 1ns / 1ps

// Watch both channels, predict each result word from the accepted input words,
// and compare what the sequencer hands out, field by field, in order.
module melody_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_ready,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [mns_pkg::ADDR_W-1:0]   i_address,
    input  wire logic [mns_pkg::PITCH_W-1:0]  i_pitch_hz,
    input  wire logic [mns_pkg::LEN_W-1:0]    i_note_length,
    input  wire logic [mns_pkg::COUNT_W-1:0]  i_note_count,
    input  wire logic [mns_pkg::BPM_W-1:0]    i_tempo_bpm,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic                         i_tone_start,
    input  wire logic [mns_pkg::PITCH_W-1:0]  i_tone_freq,
    input  wire logic [mns_pkg::MS_W-1:0]     i_tone_ms,
    input  wire logic                         i_silence,
    input  wire logic                         i_playing,
    input  wire logic                         i_song_done,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_songs_done
);

    localparam int              MEM_WORDS   = 256;
    localparam int              GAP         = 30;
    localparam int              TEMPO_MS    = 15000;
    localparam int              REST_TEMPO  = 100;
    localparam logic [21:0]     ELAPSED_TOP = 22'h3FFFFF;
    localparam int              PRINT_LIMIT = 40;

    typedef struct packed {
        logic        tone_start;
        logic [15:0] freq;
        logic [21:0] ms;
        logic        silence;
        logic        playing;
        logic        done;
    } t_player_out;

    // Player state
    logic [23:0] note_mem [MEM_WORDS];
    logic [7:0]  song_base;
    logic [8:0]  song_notes;
    logic [8:0]  note_pos;
    logic [13:0] sixteenth;
    logic [21:0] elapsed;
    logic        running;

    t_player_out awaited_out [$];

    function automatic logic [23:0] current_note();
        return note_mem[8'(song_base + note_pos[7:0])];
    endfunction

    function automatic logic [21:0] slot_ms();
        logic [23:0] w;
        w = current_note();
        return 22'(w[23:16]) * 22'(sixteenth);
    endfunction

    // Issue the current note: a tone, or silence for a rest. Restart the ms count.
    function automatic t_player_out sound_note();
        t_player_out r;
        logic [23:0] w;
        logic [21:0] slot;
        r = '0;
        w = current_note();
        slot = slot_ms();
        elapsed = '0;
        if (w[15:0] == 16'd0) begin
            r.silence = 1'b1;
        end else begin
            r.tone_start = 1'b1;
            r.freq = w[15:0];
            r.ms = (slot > 22'(GAP)) ? slot - 22'(GAP) : slot;
        end
        return r;
    endfunction

    function automatic t_player_out apply_word(
        input logic [1:0]  op,
        input logic [7:0]  addr,
        input logic [15:0] pitch,
        input logic [7:0]  len,
        input logic [8:0]  count,
        input logic [15:0] bpm
    );
        t_player_out r;
        r = '0;
        case (op)
            mns_pkg::OP_TICK: begin
                if (running) begin
                    if (elapsed != ELAPSED_TOP) elapsed = elapsed + 22'd1;
                    if (elapsed >= slot_ms()) begin
                        note_pos = note_pos + 9'd1;
                        if (note_pos >= song_notes) begin
                            running = 1'b0;
                            r.silence = 1'b1;
                            r.done = 1'b1;
                        end else begin
                            r = sound_note();
                        end
                    end
                end
            end
            mns_pkg::OP_WRITE: begin
                note_mem[addr] = {len, pitch};
            end
            mns_pkg::OP_START: begin
                if (count != 9'd0) begin
                    song_base = addr;
                    song_notes = count;
                    note_pos = '0;
                    sixteenth = (bpm != 16'd0) ? 14'(TEMPO_MS / int'(bpm)) : 14'(REST_TEMPO);
                    running = 1'b1;
                    r = sound_note();
                end
            end
            default: begin
                running = 1'b0;
                r.silence = 1'b1;
            end
        endcase
        r.playing = running;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_errors < PRINT_LIMIT)
            $display("%0t ns: result word %0d, %s is %0h, want %0h",
                     $time, o_checked, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_player_out want;
        if (!i_rst_n) begin
            song_base = '0;
            song_notes = '0;
            note_pos = '0;
            sixteenth = '0;
            elapsed = '0;
            running = 1'b0;
            awaited_out.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_out.size() == 0) begin
                    report_mismatch("unexpected word, tone_freq", 32'(i_tone_freq), 32'hx);
                end else begin
                    want = awaited_out.pop_front();
                    if (i_tone_start !== want.tone_start)
                        report_mismatch("tone_start", 32'(i_tone_start), 32'(want.tone_start));
                    if (i_tone_freq !== want.freq)
                        report_mismatch("tone_freq", 32'(i_tone_freq), 32'(want.freq));
                    if (i_tone_ms !== want.ms)
                        report_mismatch("tone_ms", 32'(i_tone_ms), 32'(want.ms));
                    if (i_silence !== want.silence)
                        report_mismatch("silence", 32'(i_silence), 32'(want.silence));
                    if (i_playing !== want.playing)
                        report_mismatch("playing", 32'(i_playing), 32'(want.playing));
                    if (i_song_done !== want.done)
                        report_mismatch("song_done", 32'(i_song_done), 32'(want.done));
                    if (want.done) o_songs_done++;
                    o_checked++;
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_out.push_back(apply_word(i_opcode, i_address, i_pitch_hz,
                                                 i_note_length, i_note_count, i_tempo_bpm));
        end
        o_pending = awaited_out.size();
    end

endmodule

/* tb/tb_melody_note_sequencer_core.sv */
`timescale 1ns / 1ps

module tb_melody_note_sequencer_core;

    localparam int ITEM_TARGET = 1400;
    localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
    localparam int TAIL_CYCLES = 40;    // covers the slowest word (tempo divide)

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = '0;
    logic [7:0]  address = '0;
    logic [15:0] pitch_hz = '0;
    logic [7:0]  note_length = '0;
    logic [8:0]  note_count = '0;
    logic [15:0] tempo_bpm = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        tone_start;
    logic [15:0] tone_freq;
    logic [21:0] tone_ms;
    logic        silence;
    logic        playing;
    logic        song_done;

    int errors;
    int pending;
    int checked;
    int songs_done;

    // Stimulus bookkeeping: which note entries hold a word, and their lengths,
    // so that no song ever reads an entry that was never written.
    bit       note_written [256];
    bit [7:0] note_len [256];

    int words_sent = 0;
    int note_writes = 0;
    int song_starts = 0;
    int drain_pauses = 0;
    int long_holds = 0;
    int rx_hold = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    melody_note_sequencer_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_opcode      (opcode),
        .i_address     (address),
        .i_pitch_hz    (pitch_hz),
        .i_note_length (note_length),
        .i_note_count  (note_count),
        .i_tempo_bpm   (tempo_bpm),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_tone_start  (tone_start),
        .o_tone_freq   (tone_freq),
        .o_tone_ms     (tone_ms),
        .o_silence     (silence),
        .o_playing     (playing),
        .o_song_done   (song_done)
    );

    melody_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_opcode      (opcode),
        .i_address     (address),
        .i_pitch_hz    (pitch_hz),
        .i_note_length (note_length),
        .i_note_count  (note_count),
        .i_tempo_bpm   (tempo_bpm),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_tone_start  (tone_start),
        .i_tone_freq   (tone_freq),
        .i_tone_ms     (tone_ms),
        .i_silence     (silence),
        .i_playing     (playing),
        .i_song_done   (song_done),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_songs_done  (songs_done)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one word after a random gap, or none in calm mode; hold it until the handshake takes it.
    // Returns right after the accepting rising edge.
    task automatic send_word(input logic [1:0] op, input logic [7:0] addr,
                             input logic [15:0] pitch, input logic [7:0] len,
                             input logic [8:0] count, input logic [15:0] bpm);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        opcode = op;
        address = addr;
        pitch_hz = pitch;
        note_length = len;
        note_count = count;
        tempo_bpm = bpm;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // Unused fields carry random junk: the block must ignore them.
    task automatic tick();
        send_word(mns_pkg::OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom),
                  9'($urandom), 16'($urandom));
    endtask

    task automatic halt();
        send_word(mns_pkg::OP_STOP, 8'($urandom), 16'($urandom), 8'($urandom),
                  9'($urandom), 16'($urandom));
    endtask

    task automatic put_note(input logic [7:0] addr, input logic [15:0] pitch,
                            input logic [7:0] len);
        send_word(mns_pkg::OP_WRITE, addr, pitch, len, 9'($urandom), 16'($urandom));
        note_written[addr] = 1'b1;
        note_len[addr] = len;
        note_writes++;
    endtask

    // Write every entry the song could reach that holds no word yet.
    task automatic start_song(input logic [7:0] addr, input logic [8:0] count,
                              input logic [15:0] bpm);
        int reach;
        reach = (count > 9'd256) ? 256 : int'(count);
        for (int i = 0; i < reach; i++)
            if (!note_written[8'(addr + i)])
                put_note(8'(addr + i), 16'($urandom), 8'($urandom_range(0, 4)));
        send_word(mns_pkg::OP_START, addr, 16'($urandom), 8'($urandom), count, bpm);
        if (count != 9'd0) song_starts++;
    endtask

    // Drop valid and hold until every result word has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        drain_pauses++;
        @(posedge clk);
    endtask

    // A well-formed phrase: write a few notes, start them, tick through the
    // song, with the odd stop, restart or rewrite thrown in along the way.
    task automatic play_phrase();
        int          n;
        int          base;
        int          t;
        int          ticks;
        int          pick;
        bit          halted;
        logic [15:0] bpm;
        tx_calm = ($urandom_range(0, 5) == 0);
        rx_calm = ($urandom_range(0, 5) == 0);
        n = $urandom_range(1, 8);
        base = $urandom_range(0, 255);
        for (int i = 0; i < n; i++)
            put_note(8'(base + i),
                     ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
                     8'($urandom_range(0, 4)));
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            t = 100;
            bpm = 16'd0;
        end else if (pick == 1) begin
            t = 0;
            bpm = 16'($urandom_range(15001, 65535));
        end else begin
            t = $urandom_range(1, 8);
            bpm = 16'($urandom_range(15000 / (t + 1) + 1, 15000 / t));
        end
        start_song(8'(base), 9'(n), bpm);
        // Ticks to play the song out: every note takes at least one tick.
        ticks = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            ticks += (note_len[8'(base + i)] * t > 0) ? note_len[8'(base + i)] * t : 1;
        if (ticks > 200) ticks = 200;
        halted = 1'b0;
        for (int k = 0; k < ticks && !halted; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                halt();
                halted = 1'b1;
            end else begin
                if (pick < 4)
                    start_song(8'(base), 9'(n), bpm);
                else if (pick < 7)
                    put_note(8'(base + $urandom_range(0, n - 1)), 16'($urandom),
                             8'($urandom_range(0, 4)));
                tick();
            end
        end
    endtask

    // One stray word: any opcode with any field values.
    task automatic random_word();
        int         pick;
        logic [8:0] count;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        case ($urandom_range(0, 3))
            0: tick();
            1: put_note(8'($urandom), 16'($urandom), 8'($urandom));
            2: begin
                pick = $urandom_range(0, 9);
                if (pick == 0) count = 9'd0;
                else if (pick == 1) count = 9'($urandom_range(257, 511));
                else count = 9'($urandom_range(1, 256));
                start_song(8'($urandom), count, 16'($urandom));
            end
            default: halt();
        endcase
    endtask

    // Result side: stall a random number of cycles before each word, or hold
    // off for a long stretch when asked so that the block backs up.
    initial begin : result_sink
        int stall;
        forever begin
            @(negedge clk);
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
                long_holds++;
            end else begin
                stall = rx_calm ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timeout: %0d words sent, %0d result words still awaited", words_sent,
                 pending);
        $display("FAIL melody_note_sequencer_core");
        $finish;
    end

    initial begin : stimulus
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle behavior and an ignored start.
        tick();
        halt();
        send_word(mns_pkg::OP_START, 8'hFF, 16'hFFFF, 8'hFF, 9'd0, 16'hFFFF);
        // Highest, longest note; a zero-length rest at the top of memory.
        put_note(8'd0, 16'hFFFF, 8'd255);
        put_note(8'd255, 16'd0, 8'd0);
        put_note(8'd1, 16'd1, 8'd1);
        // Slowest tempo: longest tone, then a tick inside the note.
        start_song(8'd0, 9'd1, 16'd1);
        tick();
        // Restart while playing from the last entry; the song wraps to entry 0.
        start_song(8'd255, 9'd2, 16'd0);
        tick();
        // Rewrite the playing note to zero length; the next tick ends the song.
        put_note(8'd0, 16'd440, 8'd0);
        tick();
        tick();
        // Short slots: one ms, then zero ms at a tempo above 15000.
        start_song(8'd1, 9'd1, 16'd15000);
        tick();
        start_song(8'd1, 9'd1, 16'hFFFF);
        halt();
        // Slot right at the gap, then one past it.
        put_note(8'd2, 16'd1000, 8'd1);
        start_song(8'd2, 9'd1, 16'd500);
        start_song(8'd2, 9'd1, 16'd483);
        halt();

        // Let the pipeline drain, then hold the result side off for a long
        // stretch while the first phrase keeps the input busy.
        wait_drained();
        rx_hold = LONG_HOLD;

        while (words_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 7) play_phrase();
            else random_word();
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d words: %0d note writes, %0d song starts, %0d songs played out.",
                 words_sent, note_writes, song_starts, songs_done);
        $display("Compared %0d result words across %0d drain pauses and %0d long hold-offs.",
                 checked, drain_pauses, long_holds);
        if (errors == 0 && pending == 0) begin
            $display("PASS melody_note_sequencer_core");
        end else begin
            $display("%0d mismatches, %0d result words missing", errors, pending);
            $display("FAIL melody_note_sequencer_core");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/mns_pkg.sv
hdl/mns_front.sv
hdl/mns_queue.sv
hdl/mns_back.sv
hdl/melody_note_sequencer_core.sv
tb/melody_checker.sv
tb/tb_melody_note_sequencer_core.sv
